[rtl/core/dpip_pkg.sv]
// shared types, codes and constants of the display power idle policy unit
package dpip_pkg;

   localparam int TIME_BITS  = 64;
   localparam int CMP_BITS   = (TIME_BITS > 32) ? TIME_BITS : 32;
   localparam int COUNT_BITS = 64;
   localparam int CFG_BITS   = 32;
   localparam int IDX_BITS   = 2;
   localparam int EVENT_BITS = 8;
   localparam int PORT_TIME  = 64;

   typedef logic [TIME_BITS-1:0]  time_type;
   typedef logic [CMP_BITS-1:0]   cmp_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [CFG_BITS-1:0]   cfg_word_type;
   typedef logic [EVENT_BITS-1:0] event_type;

   // register indexes of the configuration port
   localparam logic [IDX_BITS-1:0] REG_DIM_TIMEOUT = 2'd0;
   localparam logic [IDX_BITS-1:0] REG_OFF_TIMEOUT = 2'd1;
   localparam logic [IDX_BITS-1:0] REG_LARGE_STEP  = 2'd2;

   localparam cfg_word_type DIM_TIMEOUT_RESET = 32'd10000;
   localparam cfg_word_type OFF_TIMEOUT_RESET = 32'd30000;
   localparam cfg_word_type LARGE_STEP_RESET  = 32'd300000;

   // event word bit positions
   localparam int EV_BUTTON     = 0;
   localparam int EV_TOUCH      = 1;
   localparam int EV_NOTIFY     = 2;
   localparam int EV_WRIST      = 3;
   localparam int EV_CHARGING   = 4;
   localparam int EV_TICK       = 5;
   localparam int EV_WORKOUT_ON = 6;
   localparam int EV_WORKOUT_OFF = 7;

   localparam logic CMD_EVENT = 1'b0;
   localparam logic CMD_START = 1'b1;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_NOT_STARTED = 3'd1,
      ST_BAD_CONFIG  = 3'd2,
      ST_BAD_EVENT   = 3'd3,
      ST_ROLLBACK    = 3'd4,
      ST_DUPLICATE   = 3'd5,
      ST_LARGE_JUMP  = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      MODE_ACTIVE = 2'd0,
      MODE_DIMMED = 2'd1,
      MODE_OFF    = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      WAKE_NONE     = 3'd0,
      WAKE_BUTTON   = 3'd1,
      WAKE_TOUCH    = 3'd2,
      WAKE_NOTIFY   = 3'd3,
      WAKE_WRIST    = 3'd4,
      WAKE_CHARGING = 3'd5
   } wake_type;

   typedef struct packed {
      cfg_word_type dim_timeout;
      cfg_word_type off_timeout;
      cfg_word_type large_step_limit;
   } cfg_type;

   typedef struct packed {
      status_type status;
      mode_type   power_mode;
      wake_type   wake_cause;
      logic       in_workout;
      logic       display_on;
      count_type  mode_changes;
      time_type   activity_time;
   } result_type;

endpackage

[rtl/core/dpip_csr.sv]
// configuration registers of the display power idle policy unit
module dpip_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [dpip_pkg::IDX_BITS-1:0] csr_index,
   input  dpip_pkg::cfg_word_type       csr_data,
   output dpip_pkg::cfg_type            cfg
);

   dpip_pkg::cfg_type cfg_ff;
   dpip_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            dpip_pkg::REG_DIM_TIMEOUT: cfg_in.dim_timeout      = csr_data;
            dpip_pkg::REG_OFF_TIMEOUT: cfg_in.off_timeout      = csr_data;
            dpip_pkg::REG_LARGE_STEP:  cfg_in.large_step_limit = csr_data;
            default: ; // unused index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dim_timeout      <= dpip_pkg::DIM_TIMEOUT_RESET;
         cfg_ff.off_timeout      <= dpip_pkg::OFF_TIMEOUT_RESET;
         cfg_ff.large_step_limit <= dpip_pkg::LARGE_STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/core/dpip_core.sv]
// policy state, per-item update logic and result register
module dpip_core (
   input  logic                  clock,
   input  logic                  reset,
   input  dpip_pkg::cfg_type     cfg,
   input  logic                  fire,
   input  logic                  item_cmd,
   input  dpip_pkg::time_type    item_time,
   input  dpip_pkg::event_type   item_event,
   input  logic                  rsp_take,
   output logic                  rsp_valid,
   output dpip_pkg::result_type  rsp_result
);

   logic                 started_ff, started_in;
   dpip_pkg::mode_type   mode_ff, mode_in;
   dpip_pkg::wake_type   wake_ff, wake_in;
   logic                 workout_ff, workout_in;
   dpip_pkg::time_type   activity_ff, activity_in;
   dpip_pkg::time_type   seen_ff, seen_in;
   dpip_pkg::count_type  count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   dpip_pkg::result_type result_ff, result_in;

   logic                 cfg_ok;
   logic                 bad_event;
   dpip_pkg::wake_type   wake_pick;
   dpip_pkg::time_type   step_diff;
   dpip_pkg::time_type   idle;
   dpip_pkg::status_type status;
   dpip_pkg::mode_type   target;
   logic                 set_mode;

   assign cfg_ok = (cfg.dim_timeout != '0) && (cfg.off_timeout > cfg.dim_timeout)
                   && (cfg.large_step_limit >= cfg.off_timeout);

   assign bad_event = (item_event == '0)
                      || (item_event[dpip_pkg::EV_WORKOUT_ON]
                          && item_event[dpip_pkg::EV_WORKOUT_OFF]);

   assign step_diff = item_time - seen_ff;
   assign idle      = item_time - activity_ff;

   // fixed priority, button first
   always_comb begin
      if (item_event[dpip_pkg::EV_BUTTON]) begin
         wake_pick = dpip_pkg::WAKE_BUTTON;
      end else if (item_event[dpip_pkg::EV_TOUCH]) begin
         wake_pick = dpip_pkg::WAKE_TOUCH;
      end else if (item_event[dpip_pkg::EV_NOTIFY]) begin
         wake_pick = dpip_pkg::WAKE_NOTIFY;
      end else if (item_event[dpip_pkg::EV_WRIST]) begin
         wake_pick = dpip_pkg::WAKE_WRIST;
      end else if (item_event[dpip_pkg::EV_CHARGING]) begin
         wake_pick = dpip_pkg::WAKE_CHARGING;
      end else begin
         wake_pick = dpip_pkg::WAKE_NONE;
      end
   end

   always_comb begin
      started_in  = started_ff;
      mode_in     = mode_ff;
      wake_in     = wake_ff;
      workout_in  = workout_ff;
      activity_in = activity_ff;
      seen_in     = seen_ff;
      count_in    = count_ff;
      status      = dpip_pkg::ST_OK;
      target      = dpip_pkg::MODE_ACTIVE;
      set_mode    = 1'b0;

      if (item_cmd == dpip_pkg::CMD_START) begin
         if (!cfg_ok) begin
            status = dpip_pkg::ST_BAD_CONFIG;
         end else begin
            started_in  = 1'b1;
            mode_in     = dpip_pkg::MODE_ACTIVE;
            wake_in     = dpip_pkg::WAKE_NONE;
            workout_in  = 1'b0;
            activity_in = item_time;
            seen_in     = item_time;
            count_in    = '0;
         end
      end else if (!started_ff) begin
         status = dpip_pkg::ST_NOT_STARTED;
      end else if (!cfg_ok) begin
         status = dpip_pkg::ST_BAD_CONFIG;
      end else if (bad_event) begin
         status = dpip_pkg::ST_BAD_EVENT;
      end else if (item_time < seen_ff) begin
         status = dpip_pkg::ST_ROLLBACK;
      end else begin
         if (item_time == seen_ff) begin
            status = dpip_pkg::ST_DUPLICATE;
         end else if (dpip_pkg::cmp_type'(step_diff)
                      > dpip_pkg::cmp_type'(cfg.large_step_limit)) begin
            status = dpip_pkg::ST_LARGE_JUMP;
         end
         seen_in = item_time;
         if (item_event[dpip_pkg::EV_WORKOUT_ON]) begin
            workout_in = 1'b1;
         end else if (item_event[dpip_pkg::EV_WORKOUT_OFF]) begin
            workout_in = 1'b0;
         end
         if (wake_pick != dpip_pkg::WAKE_NONE) begin
            set_mode    = 1'b1;
            target      = dpip_pkg::MODE_ACTIVE;
            wake_in     = wake_pick;
            activity_in = item_time;
         end else if (item_event[dpip_pkg::EV_TICK]) begin
            set_mode = 1'b1;
            if (dpip_pkg::cmp_type'(idle) >= dpip_pkg::cmp_type'(cfg.off_timeout)) begin
               target = dpip_pkg::MODE_OFF;
            end else if (dpip_pkg::cmp_type'(idle)
                         >= dpip_pkg::cmp_type'(cfg.dim_timeout)) begin
               target = dpip_pkg::MODE_DIMMED;
            end else begin
               target = dpip_pkg::MODE_ACTIVE;
            end
         end
         if (set_mode && (target != mode_ff)) begin
            mode_in = target;
            if (count_ff != '1) begin
               count_in = count_ff + dpip_pkg::count_type'(1);
            end
         end
      end
   end

   always_comb begin
      result_in.status        = status;
      result_in.power_mode    = mode_in;
      result_in.wake_cause    = wake_in;
      result_in.in_workout    = workout_in;
      result_in.display_on    = (mode_in != dpip_pkg::MODE_OFF);
      result_in.mode_changes  = count_in;
      result_in.activity_time = activity_in;
   end

   always_comb begin
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         mode_ff      <= dpip_pkg::MODE_ACTIVE;
         wake_ff      <= dpip_pkg::WAKE_NONE;
         workout_ff   <= 1'b0;
         activity_ff  <= '0;
         seen_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            started_ff  <= started_in;
            mode_ff     <= mode_in;
            wake_ff     <= wake_in;
            workout_ff  <= workout_in;
            activity_ff <= activity_in;
            seen_ff     <= seen_in;
            count_ff    <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = result_ff;

endmodule

[rtl/core/display_power_idle_policy_unit.sv]
// display power idle policy unit: top level with input register and stream ports
// an accepted item passes the input register and then the result register before its result
// is valid; a stalled result register holds the item in the input register
// throughput: one item per cycle while the result is not stalled; the state update and the
// 64-bit time compares sit in one stage. The input register refills while the result register
// is being taken, so stalls cost no bubble. Reset: synchronous, clears both registers' valid
// flags, the policy state (not started, active) and loads the configuration registers with their defaults
module display_power_idle_policy_unit (
   input  logic          clock,
   input  logic          reset,
   // item input
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [71:0]   req_tdata,   // time_ms[63:0], event_bits[71:64]
   input  logic          req_tuser,   // cmd
   // result output
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [143:0]  rsp_tdata,   // status[2:0], power_mode[4:3], wake_cause[7:5],
                                      // in_workout[8], display_on[9], mode_changes[73:10],
                                      // activity_time[137:74], zero fill[143:138]
   // configuration writes
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [31:0]   csr_data
);

   dpip_pkg::cfg_type    cfg;
   dpip_pkg::result_type result;

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic                 in_cmd_ff;
   dpip_pkg::time_type   in_time_ff;
   dpip_pkg::event_type  in_event_ff;

   logic                 accept;
   logic                 advance;   // result register free this cycle
   logic                 fire;      // held item moves into the policy stage
   logic                 rsp_valid;
   logic                 rsp_take;

   assign rsp_take   = rsp_valid && rsp_tready;
   assign advance    = !rsp_valid || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   // keep the valid flag when a new item replaces the one leaving
   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload, no reset; the time is taken modulo the time width
   always_ff @(posedge clock) begin
      if (accept) begin
         in_cmd_ff   <= req_tuser;
         in_time_ff  <= dpip_pkg::time_type'(req_tdata[dpip_pkg::PORT_TIME-1:0]);
         in_event_ff <= req_tdata[71:64];
      end
   end

   dpip_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   dpip_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .fire       (fire),
      .item_cmd   (in_cmd_ff),
      .item_time  (in_time_ff),
      .item_event (in_event_ff),
      .rsp_take   (rsp_take),
      .rsp_valid  (rsp_valid),
      .rsp_result (result)
   );

   assign rsp_tvalid = rsp_valid;

   // pack the result, first field lowest
   assign rsp_tdata = {6'b0,
                       64'(result.activity_time),
                       64'(result.mode_changes),
                       result.display_on,
                       result.in_workout,
                       result.wake_cause,
                       result.power_mode,
                       result.status};

endmodule
